### rtl/core/cspt_pkg.sv
`default_nettype none

package cspt_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned DurW   = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned SumW   = 64;

  typedef struct packed {
    logic [AddrW-1:0]  caller;
    logic [AddrW-1:0]  callee;
    logic [CountW-1:0] count;
    logic [SumW-1:0]   sum;
    logic [DurW-1:0]   least;
    logic [DurW-1:0]   most;
  } entry_t;

  typedef struct packed {
    logic [AddrW-1:0] caller;
    logic [AddrW-1:0] callee;
    logic [DurW-1:0]  dur;
  } key_t;

  typedef struct packed {
    logic wr;
    logic upd;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/cspt_if.sv
`default_nettype none

interface cspt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] caller_addr;
  logic [31:0] callee_addr;
  logic [47:0] duration;

  modport source (output valid, output func, output caller_addr, output callee_addr,
                  output duration, input ready);
  modport sink (input valid, input func, input caller_addr, input callee_addr,
                input duration, output ready);
endinterface

interface cspt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_caller;
  logic [31:0] out_callee;
  logic [31:0] call_count;
  logic [63:0] cycle_total;
  logic [47:0] cycle_least;
  logic [47:0] cycle_most;
  logic        last_entry;

  modport source (output valid, output out_caller, output out_callee, output call_count,
                  output cycle_total, output cycle_least, output cycle_most,
                  output last_entry, input ready);
  modport sink (input valid, input out_caller, input out_callee, input call_count,
                input cycle_total, input cycle_least, input cycle_most,
                input last_entry, output ready);
endinterface

`default_nettype wire

### rtl/core/cspt_cell.sv
`default_nettype none

module cspt_cell (
  input  wire logic                clk_i,
  input  wire logic                valid_i,
  input  wire cspt_pkg::key_t      key_i,
  input  wire cspt_pkg::cell_ctrl_t ctrl_i,
  input  wire cspt_pkg::entry_t    nbr_i,
  output cspt_pkg::entry_t         entry_o,
  output logic                     hit_o
);

  cspt_pkg::entry_t entry_q, entry_d;
  logic [cspt_pkg::SumW:0] sum_add;
  logic [cspt_pkg::SumW-1:0] dur_ext;

  assign hit_o   = valid_i && (entry_q.caller == key_i.caller)
                   && (entry_q.callee == key_i.callee);
  assign entry_o = entry_q;
  assign dur_ext = cspt_pkg::SumW'(key_i.dur);
  assign sum_add = {1'b0, entry_q.sum} + {1'b0, dur_ext};

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr) begin
      entry_d.caller = key_i.caller;
      entry_d.callee = key_i.callee;
      entry_d.count  = cspt_pkg::CountW'(1);
      entry_d.sum    = dur_ext;
      entry_d.least  = key_i.dur;
      entry_d.most   = key_i.dur;
    end else if (ctrl_i.shift) begin
      entry_d = nbr_i;
    end else if (ctrl_i.upd && hit_o) begin
      if (entry_q.count != '1) begin
        entry_d.count = entry_q.count + cspt_pkg::CountW'(1);
      end
      entry_d.sum = sum_add[cspt_pkg::SumW] ? '1 : sum_add[cspt_pkg::SumW-1:0];
      if (key_i.dur < entry_q.least) begin
        entry_d.least = key_i.dur;
      end
      if (key_i.dur > entry_q.most) begin
        entry_d.most = key_i.dur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

### rtl/core/call_site_profile_table.sv
// Record transaction: accepted in idle, then matched against the cell row in parallel.
// Flush, or a miss on a full table: each valid entry is emitted in turn, shifted out
// of cell zero as the sink takes it; one transaction in flight.
// Reset clears the fill count and control state; entry contents stay undefined
// until written and are never read before that.
`default_nettype none

module call_site_profile_table #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cspt_in_if.sink    in_i,
  cspt_out_if.source out_o
);

  localparam int unsigned FillW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DRAIN
  } state_e;

  state_e             state_q, state_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               pend_q, pend_d;
  logic               func_q, func_d;
  cspt_pkg::key_t     key_q, key_d;

  cspt_pkg::entry_t     entries [TABLE_ENTRIES];
  cspt_pkg::cell_ctrl_t ctrl [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit;

  logic any_hit, full, out_fire, last_out, final_fire;

  assign any_hit    = |hit;
  assign full       = (fill_q == FillW'(TABLE_ENTRIES));
  assign out_fire   = out_o.valid && out_o.ready;
  assign last_out   = (fill_q == FillW'(1));
  assign final_fire = (state_q == ST_DRAIN) && out_fire && last_out;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    cspt_pkg::entry_t nbr;
    logic lookup_wr;

    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entries[i+1];
    end

    assign lookup_wr = (state_q == ST_LOOKUP) && !func_q && !any_hit && !full
                       && (fill_q == FillW'(i));
    assign ctrl[i].wr    = lookup_wr || ((i == 0) && final_fire && pend_q);
    assign ctrl[i].upd   = (state_q == ST_LOOKUP) && !func_q;
    assign ctrl[i].shift = (state_q == ST_DRAIN) && out_fire;

    cspt_cell u_cell (
      .clk_i   (clk_i),
      .valid_i (FillW'(i) < fill_q),
      .key_i   (key_q),
      .ctrl_i  (ctrl[i]),
      .nbr_i   (nbr),
      .entry_o (entries[i]),
      .hit_o   (hit[i])
    );
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_DRAIN);
  assign out_o.out_caller  = entries[0].caller;
  assign out_o.out_callee  = entries[0].callee;
  assign out_o.call_count  = entries[0].count;
  assign out_o.cycle_total = entries[0].sum;
  assign out_o.cycle_least = entries[0].least;
  assign out_o.cycle_most  = entries[0].most;
  assign out_o.last_entry  = last_out;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    pend_d  = pend_q;
    func_d  = func_q;
    key_d   = key_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          func_d     = in_i.func;
          key_d.caller = in_i.caller_addr;
          key_d.callee = in_i.callee_addr;
          key_d.dur    = in_i.duration;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (func_q) begin
          pend_d  = 1'b0;
          state_d = (fill_q == '0) ? ST_IDLE : ST_DRAIN;
        end else if (any_hit) begin
          state_d = ST_IDLE;
        end else if (!full) begin
          fill_d  = fill_q + FillW'(1);
          state_d = ST_IDLE;
        end else begin
          pend_d  = 1'b1;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          fill_d = fill_q - FillW'(1);
          if (last_out) begin
            if (pend_q) begin
              fill_d = FillW'(1);
            end
            pend_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
      func_q  <= 1'b0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      func_q  <= func_d;
      key_q   <= key_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(TABLE_ENTRIES))
    else $error("fill count exceeds table size");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> fill_q != '0)
    else $error("emitting from an empty table");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> $onehot0(hit))
    else $error("key matched more than one entry");

  a_insert_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (final_fire && pend_q) |=> (fill_q == FillW'(1)) && (state_q == ST_IDLE))
    else $error("pending key not inserted after full-table drain");

endmodule

`default_nettype wire
